// ===== src/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constants for the box collision resolver
// Field widths, register indexes and the stage records of the pipeline.
// ----------------------------------------------------------------------------
package acr_pkg;

	localparam int POS_W   = 24;
	localparam int SIZE_W  = 23;
	localparam int MASS_W  = 16;
	localparam int VEL_W   = 16;
	localparam int ELAST_W = 9;
	localparam int CUT_W   = 15;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 15;
	localparam int SHARE_W = 17;
	localparam int DIV_STEPS = 16;
	localparam logic [ELAST_W-1:0] ELAST_RST = 9'd128;
	localparam logic [CUT_W-1:0]   CUT_RST   = 15'd13;
	localparam logic [SHARE_W-1:0] SHARE_ONE = 17'h10000;

	typedef enum logic [IDX_W-1:0] {
		REG_ELAST  = 2'd0,
		REG_CUTOFF = 2'd1
	} reg_idx_t;

	// edges, sums and doubled centers of both boxes, total mass and A's velocity
	typedef struct packed {
		logic signed [23:0] ix0;
		logic signed [23:0] iy0;
		logic signed [24:0] ax1;
		logic signed [24:0] bx1;
		logic signed [24:0] ay1;
		logic signed [24:0] by1;
		logic signed [25:0] cxa;
		logic signed [25:0] cxb;
		logic signed [25:0] cya;
		logic signed [25:0] cyb;
		logic signed [15:0] am;
		logic signed [16:0] total;
		logic               bm_neg;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} st1_t;

	typedef struct packed {
		logic signed [23:0] ix0;
		logic signed [23:0] iy0;
		logic signed [24:0] ix1;
		logic signed [24:0] iy1;
		logic               dir_x;
		logic               dir_y;
		logic               landed;
		logic               s_zero;
		logic               s_one;
		logic [14:0]        am;
		logic [15:0]        den;
		logic               bm_neg;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} st2_t;

	// record carried through the divider steps
	typedef struct packed {
		logic               hit;
		logic               use_x;
		logic [24:0]        ov;
		logic               dir;
		logic               landed;
		logic               s_zero;
		logic               s_one;
		logic               bm_neg;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic [16:0]        rem;
		logic [15:0]        quo;
		logic [15:0]        den;
	} dv_t;

	typedef struct packed {
		logic               hit;
		logic               use_x;
		logic               dir;
		logic               landed;
		logic [41:0]        prod_a;
		logic [41:0]        prod_b;
		logic signed [25:0] pv;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} st4_t;

endpackage

// ===== src/aabb_collision_resolver.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_resolver: overlap test and push-apart for two boxes
// Overlap rectangle, mass-shared separation along the smaller overlap axis,
// bounce of A's velocity on that axis and a landed flag.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  input    | in_valid / in_ready   | boxes A and B, masses, A's velocity
//  result   | out_valid / out_ready | hit, moves of A and B, new velocity, landed
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle unless the result stalls. Stages: three setup stages, 16 steps of the
//  share divider (one quotient bit each), one multiply stage, result register.
//  The divider length sets the latency. Reset clears valid bits and loads
//  register defaults. A stalled result freezes the whole pipeline; in_ready
//  follows the stall. cfg_ready is always high.
// ----------------------------------------------------------------------------
module aabb_collision_resolver
	import acr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [DATA_W-1:0]         cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [POS_W-1:0]   a_left,
	input  logic signed [POS_W-1:0]   a_top,
	input  logic [SIZE_W-1:0]         a_width,
	input  logic [SIZE_W-1:0]         a_height,
	input  logic signed [POS_W-1:0]   b_left,
	input  logic signed [POS_W-1:0]   b_top,
	input  logic [SIZE_W-1:0]         b_width,
	input  logic [SIZE_W-1:0]         b_height,
	input  logic signed [MASS_W-1:0]  a_mass,
	input  logic signed [MASS_W-1:0]  b_mass,
	input  logic signed [VEL_W-1:0]   a_vel_x,
	input  logic signed [VEL_W-1:0]   a_vel_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic signed [POS_W-1:0]   a_move_x,
	output logic signed [POS_W-1:0]   a_move_y,
	output logic signed [POS_W-1:0]   b_move_x,
	output logic signed [POS_W-1:0]   b_move_y,
	output logic signed [VEL_W-1:0]   new_vel_x,
	output logic signed [VEL_W-1:0]   new_vel_y,
	output logic                      landed
);

	localparam int STEPS = DIV_STEPS;

	logic [ELAST_W-1:0] elast_q;
	logic [CUT_W-1:0]   cutoff_q;
	logic               adv;

	st1_t st1_d, st1_s1;
	st2_t st2_d, st2_s2;
	dv_t  dv_d, dv_s3;
	dv_t  dv_s [STEPS];
	dv_t  dv_in [STEPS];
	st4_t st4_d, st4_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [STEPS-1:0] dv_v_s;

	logic               hit_q, landed_q, out_valid_q;
	logic signed [23:0] amx_q, amy_q, bmx_q, bmy_q;
	logic signed [15:0] nvx_q, nvy_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elast_q  <= ELAST_RST;
			cutoff_q <= CUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ELAST:  elast_q  <= cfg_data[ELAST_W-1:0];
				REG_CUTOFF: cutoff_q <= cfg_data[CUT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: edges, far corners, doubled centers, total mass
	always_comb begin
		st1_d.ix0   = (a_left > b_left) ? a_left : b_left;
		st1_d.iy0   = (a_top > b_top) ? a_top : b_top;
		st1_d.ax1   = 25'(a_left) + $signed({2'b0, a_width});
		st1_d.bx1   = 25'(b_left) + $signed({2'b0, b_width});
		st1_d.ay1   = 25'(a_top) + $signed({2'b0, a_height});
		st1_d.by1   = 25'(b_top) + $signed({2'b0, b_height});
		st1_d.cxa   = (26'(a_left) <<< 1) + $signed({3'b0, a_width});
		st1_d.cxb   = (26'(b_left) <<< 1) + $signed({3'b0, b_width});
		st1_d.cya   = (26'(a_top) <<< 1) + $signed({3'b0, a_height});
		st1_d.cyb   = (26'(b_top) <<< 1) + $signed({3'b0, b_height});
		st1_d.am    = a_mass;
		st1_d.total = 17'(a_mass) + 17'(b_mass);
		st1_d.bm_neg = b_mass[MASS_W-1];
		st1_d.vx    = a_vel_x;
		st1_d.vy    = a_vel_y;
	end

	// stage 2: near corners, directions, landed test, share cases
	always_comb begin
		st2_d.ix0    = st1_s1.ix0;
		st2_d.iy0    = st1_s1.iy0;
		st2_d.ix1    = (st1_s1.ax1 < st1_s1.bx1) ? st1_s1.ax1 : st1_s1.bx1;
		st2_d.iy1    = (st1_s1.ay1 < st1_s1.by1) ? st1_s1.ay1 : st1_s1.by1;
		st2_d.dir_x  = st1_s1.cxa > st1_s1.cxb;
		st2_d.dir_y  = st1_s1.cya > st1_s1.cyb;
		st2_d.landed = st1_s1.cya < (26'(st1_s1.iy0) <<< 1);
		st2_d.s_zero = st1_s1.am[15] || (st1_s1.total <= 17'sd0);
		st2_d.s_one  = 17'(st1_s1.am) >= st1_s1.total;
		st2_d.am     = st1_s1.am[14:0];
		st2_d.den    = st1_s1.total[15:0];
		st2_d.bm_neg = st1_s1.bm_neg;
		st2_d.vx     = st1_s1.vx;
		st2_d.vy     = st1_s1.vy;
	end

	// stage 3: overlap sizes, hit, axis choice, divider seed
	always_comb begin
		logic signed [25:0] ow, oh;
		ow = 26'(st2_s2.ix1) - 26'(st2_s2.ix0);
		oh = 26'(st2_s2.iy1) - 26'(st2_s2.iy0);
		dv_d.hit    = (ow > 26'sd0) && (oh > 26'sd0);
		dv_d.use_x  = ow < oh;
		dv_d.ov     = dv_d.use_x ? ow[24:0] : oh[24:0];
		dv_d.dir    = dv_d.use_x ? st2_s2.dir_x : st2_s2.dir_y;
		dv_d.landed = st2_s2.landed;
		dv_d.s_zero = st2_s2.s_zero;
		dv_d.s_one  = st2_s2.s_one;
		dv_d.bm_neg = st2_s2.bm_neg;
		dv_d.vx     = st2_s2.vx;
		dv_d.vy     = st2_s2.vy;
		dv_d.rem    = {2'b0, st2_s2.am};
		dv_d.quo    = '0;
		dv_d.den    = st2_s2.den;
	end

	// divider: one quotient bit per step
	for (genvar k = 0; k < STEPS; k++) begin : g_div
		dv_t src;
		logic [16:0] r2;
		assign src = (k == 0) ? dv_s3 : dv_s[(k == 0) ? 0 : k-1];
		assign r2  = {src.rem[15:0], 1'b0};
		always_comb begin
			dv_in[k] = src;
			if (r2 >= {1'b0, src.den}) begin
				dv_in[k].rem = r2 - {1'b0, src.den};
				dv_in[k].quo = {src.quo[14:0], 1'b1};
			end else begin
				dv_in[k].rem = r2;
				dv_in[k].quo = {src.quo[14:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= (k == 0) ? v_s3 : dv_v_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k] <= dv_in[k];
			end
		end
	end

	// stage 4: shares times overlap, elasticity times velocity
	always_comb begin
		dv_t d;
		logic [16:0] sa, sb;
		logic signed [15:0] vsel;
		d = dv_s[STEPS-1];
		sa = d.s_zero ? '0 : (d.s_one ? SHARE_ONE : {1'b0, d.quo});
		sb = d.bm_neg ? '0 : SHARE_ONE - sa;
		vsel = d.use_x ? d.vx : d.vy;
		st4_d.hit    = d.hit;
		st4_d.use_x  = d.use_x;
		st4_d.dir    = d.dir;
		st4_d.landed = d.landed;
		st4_d.prod_a = 42'(d.ov) * 42'(sa);
		st4_d.prod_b = 42'(d.ov) * 42'(sb);
		st4_d.pv     = $signed({17'b0, elast_q}) * 26'(vsel);
		st4_d.vx     = d.vx;
		st4_d.vy     = d.vy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv_v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st1_s1 <= st1_d;
			st2_s2 <= st2_d;
			dv_s3  <= dv_d;
			st4_s4 <= st4_d;
		end
	end

	// result stage: direction, bounce with cutoff and saturation
	logic [23:0]        mag_a, mag_b, mv_a, mv_b;
	logic [24:0]        pmag;
	logic signed [15:0] bnc;

	always_comb begin
		mag_a = st4_s4.prod_a[39:16];
		mag_b = st4_s4.prod_b[39:16];
		mv_a  = st4_s4.dir ? mag_a : 24'(-mag_a);
		mv_b  = st4_s4.dir ? 24'(-mag_b) : mag_b;
		pmag  = st4_s4.pv[25] ? 25'(-st4_s4.pv) >> 8 : 25'(st4_s4.pv) >> 8;
		if (pmag < 25'(cutoff_q)) begin
			bnc = '0;
		end else if (st4_s4.pv > 26'sd0) begin
			bnc = (pmag > 25'd32768) ? -16'sd32768 : 16'(-pmag);
		end else begin
			bnc = (pmag > 25'd32767) ? 16'sd32767 : 16'(pmag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q    <= st4_s4.hit;
			landed_q <= st4_s4.hit && st4_s4.landed;
			amx_q    <= (st4_s4.hit && st4_s4.use_x) ? mv_a : '0;
			bmx_q    <= (st4_s4.hit && st4_s4.use_x) ? mv_b : '0;
			amy_q    <= (st4_s4.hit && !st4_s4.use_x) ? mv_a : '0;
			bmy_q    <= (st4_s4.hit && !st4_s4.use_x) ? mv_b : '0;
			nvx_q    <= (st4_s4.hit && st4_s4.use_x) ? bnc : st4_s4.vx;
			nvy_q    <= (st4_s4.hit && !st4_s4.use_x) ? bnc : st4_s4.vy;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign landed    = landed_q;
	assign a_move_x  = amx_q;
	assign a_move_y  = amy_q;
	assign b_move_x  = bmx_q;
	assign b_move_y  = bmy_q;
	assign new_vel_x = nvx_q;
	assign new_vel_y = nvy_q;

endmodule

// ===== src/acr_checker.sv =====
// ----------------------------------------------------------------------------
// acr_checker: port-level checks for the box collision resolver
// Watches the result channel and the consistency of the result fields.
// ----------------------------------------------------------------------------
module acr_checker
	import acr_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     hit,
	input logic                     landed,
	input logic signed [POS_W-1:0]  a_move_x,
	input logic signed [POS_W-1:0]  a_move_y,
	input logic signed [POS_W-1:0]  b_move_x,
	input logic signed [POS_W-1:0]  b_move_y
);

	// a stalled result stays valid and A's moves hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(a_move_x) && $stable(a_move_y))
		else $error("result changed while stalled");

	a_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> a_move_x == '0 && a_move_y == '0 &&
			b_move_x == '0 && b_move_y == '0 && !landed)
		else $error("moves or landed without a hit");

	// only one axis is resolved per item
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (a_move_x != '0 || b_move_x != '0) |->
			a_move_y == '0 && b_move_y == '0)
		else $error("moves on both axes");

endmodule

bind aabb_collision_resolver acr_checker u_acr_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.hit(hit), .landed(landed), .a_move_x(a_move_x), .a_move_y(a_move_y),
	.b_move_x(b_move_x), .b_move_y(b_move_y)
);

// ===== dv/aabb_collision_resolver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_collision_resolver_tb: self-checking bench for the box collision resolver
// Streams box pairs through the block under several register settings and
// random idling on both channels. A scoreboard predicts every result and
// compares it, field by field, with what comes out, in order.
// ----------------------------------------------------------------------------
module aabb_collision_resolver_tb
	import acr_pkg::*;
();

	typedef struct packed {
		logic signed [23:0] a_left;
		logic signed [23:0] a_top;
		logic [22:0]        a_width;
		logic [22:0]        a_height;
		logic signed [23:0] b_left;
		logic signed [23:0] b_top;
		logic [22:0]        b_width;
		logic [22:0]        b_height;
		logic signed [15:0] a_mass;
		logic signed [15:0] b_mass;
		logic signed [15:0] a_vel_x;
		logic signed [15:0] a_vel_y;
	} pair_t;

	typedef struct packed {
		logic               hit;
		logic signed [23:0] a_move_x;
		logic signed [23:0] a_move_y;
		logic signed [23:0] b_move_x;
		logic signed [23:0] b_move_y;
		logic signed [15:0] new_vel_x;
		logic signed [15:0] new_vel_y;
		logic               landed;
	} resolve_t;

	class collision_scoreboard;
		resolve_t pending[$];
		logic [ELAST_W-1:0] elast = ELAST_RST;
		logic [CUT_W-1:0]   cut   = CUT_RST;
		int mismatches = 0;
		int checked = 0;

		function longint bounce_vel(longint v);
			longint p, mag;
			p = longint'(elast) * v;
			mag = (p < 0 ? -p : p) >>> 8;
			if (mag < longint'(cut))
				return 0;
			if (p > 0)
				return (-mag < -32768) ? -32768 : -mag;
			return (mag > 32767) ? 32767 : mag;
		endfunction

		function void note_pair(pair_t b);
			longint al, at, aw, ah, bl, bt, bw, bh, am, bm, ix0, ix1, iy0, iy1;
			longint ow, oh, total, share, share_b, dir;
			resolve_t r;
			al = b.a_left;  at = b.a_top;  aw = b.a_width;  ah = b.a_height;
			bl = b.b_left;  bt = b.b_top;  bw = b.b_width;  bh = b.b_height;
			am = b.a_mass;  bm = b.b_mass;
			ix0 = al > bl ? al : bl;
			ix1 = (al + aw) < (bl + bw) ? al + aw : bl + bw;
			iy0 = at > bt ? at : bt;
			iy1 = (at + ah) < (bt + bh) ? at + ah : bt + bh;
			r = '0;
			r.new_vel_x = b.a_vel_x;
			r.new_vel_y = b.a_vel_y;
			r.hit = (ix0 < ix1) && (iy0 < iy1);
			if (r.hit) begin
				ow = ix1 - ix0;
				oh = iy1 - iy0;
				total = am + bm;
				share = 0;
				if (am >= 0 && total > 0)
					share = (am >= total) ? 65536 : (am * 65536) / total;
				share_b = (bm < 0) ? 0 : 65536 - share;
				if (ow < oh) begin
					dir = (2 * al + aw > 2 * bl + bw) ? 1 : -1;
					r.a_move_x = 24'(dir * ((ow * share) >>> 16));
					r.b_move_x = 24'(-dir * ((ow * share_b) >>> 16));
					r.new_vel_x = 16'(bounce_vel(longint'(b.a_vel_x)));
				end else begin
					dir = (2 * at + ah > 2 * bt + bh) ? 1 : -1;
					r.a_move_y = 24'(dir * ((oh * share) >>> 16));
					r.b_move_y = 24'(-dir * ((oh * share_b) >>> 16));
					r.new_vel_y = 16'(bounce_vel(longint'(b.a_vel_y)));
				end
				r.landed = (2 * at + ah) < 2 * iy0;
			end
			pending.push_back(r);
		endfunction

		function void check_result(resolve_t got);
			resolve_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result %p", $time, got);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.hit !== want.hit || got.a_move_x !== want.a_move_x ||
			    got.a_move_y !== want.a_move_y || got.b_move_x !== want.b_move_x ||
			    got.b_move_y !== want.b_move_y || got.new_vel_x !== want.new_vel_x ||
			    got.new_vel_y !== want.new_vel_y || got.landed !== want.landed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] mismatch\n  expected %p\n  actual   %p", $time, want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	pair_t pair = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	resolve_t res;

	int tx_idle = 0;
	int rx_idle = 0;
	int sent = 0;
	collision_scoreboard board = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	aabb_collision_resolver dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_left(pair.a_left), .a_top(pair.a_top),
		.a_width(pair.a_width), .a_height(pair.a_height),
		.b_left(pair.b_left), .b_top(pair.b_top),
		.b_width(pair.b_width), .b_height(pair.b_height),
		.a_mass(pair.a_mass), .b_mass(pair.b_mass),
		.a_vel_x(pair.a_vel_x), .a_vel_y(pair.a_vel_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(res.hit), .a_move_x(res.a_move_x), .a_move_y(res.a_move_y),
		.b_move_x(res.b_move_x), .b_move_y(res.b_move_y),
		.new_vel_x(res.new_vel_x), .new_vel_y(res.new_vel_y), .landed(res.landed)
	);

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(res);
	end

	task automatic write_reg(reg_idx_t idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ELAST)
			board.elast = ELAST_W'(value);
		else
			board.cut = CUT_W'(value);
	endtask

	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pair <= p;
		do @(posedge clk); while (!in_ready);
		board.note_pair(p);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_mass();
		case ($urandom_range(5))
			0: return '0;
			1: return 16'(-$urandom_range(1, 32768));
			2: return 16'($urandom_range(1, 16));
			3: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly overlapping small boxes; the rest are noise over the whole range
	function automatic pair_t random_pair();
		pair_t p;
		p = 252'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		if ($urandom_range(9) < 8) begin
			if ($urandom_range(3) == 0) begin
				p.a_left = $urandom_range(1) ? 24'sh7f0000 : -24'sh7f0000;
				p.a_top  = $urandom_range(1) ? -24'sh7f0000 : 24'sh7f0000;
			end else begin
				p.a_left = $signed(24'($urandom)) >>> 2;
				p.a_top  = $signed(24'($urandom)) >>> 2;
			end
			p.a_width  = 23'($urandom_range(0, 8192));
			p.a_height = 23'($urandom_range(0, 8192));
			p.b_width  = 23'($urandom_range(0, 8192));
			p.b_height = 23'($urandom_range(0, 8192));
			p.b_left = p.a_left + $signed(24'($urandom_range(0, 16384))) - 24'sd8192;
			p.b_top  = p.a_top + $signed(24'($urandom_range(0, 16384))) - 24'sd8192;
			p.a_mass = pick_mass();
			p.b_mass = pick_mass();
		end
		return p;
	endfunction

	function automatic pair_t box_pair(int al, int at, int aw, int ah, int bl, int bt,
			int bw, int bh, int am, int bm, int vx, int vy);
		return {24'(al), 24'(at), 23'(aw), 23'(ah), 24'(bl), 24'(bt), 23'(bw), 23'(bh),
			16'(am), 16'(bm), 16'(vx), 16'(vy)};
	endfunction

	initial begin
		int phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: separation, edge contact, equal overlap, equal centers,
		// immovable and massless bodies, extremes of every field
		send_pair(box_pair(0, 0, 256, 256, 1000, 1000, 256, 256, 1, 1, 100, 100));
		send_pair(box_pair(0, 0, 256, 256, 256, 0, 256, 256, 1, 1, 100, 100));
		send_pair(box_pair(0, 0, 0, 256, 0, 0, 256, 256, 1, 1, 100, 100));
		send_pair(box_pair(0, 0, 512, 512, 0, 0, 512, 512, 3, 5, 600, -600));
		send_pair(box_pair(0, 0, 512, 512, 256, 256, 512, 512, 3, 5, 600, -600));
		send_pair(box_pair(0, 0, 1024, 256, 0, 128, 1024, 256, 1, 1, 50, 900));
		send_pair(box_pair(0, 200, 1024, 256, 0, 0, 1024, 256, 1, 1, 50, -900));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, 1, 1, -900, 5));
		send_pair(box_pair(200, 0, 256, 1024, 0, 0, 256, 1024, 1, 1, 900, 5));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, -1, 4, -900, 5));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, 4, -1, -900, 5));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, 0, 0, -900, 5));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, 7, -3, -900, 5));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, -5, -5, -900, 5));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, 32767, 1, -32768, 5));
		send_pair(box_pair(0, 0, 256, 1024, 200, 0, 256, 1024, -32768, 32767, 32767, 5));
		send_pair(box_pair(0, 0, 1024, 256, 0, 100, 1024, 256, 1, 2, 5, 20));
		send_pair(box_pair(-8388608, -8388608, 8388607, 8388607, -8388608, -8388608,
			8388607, 8388607, 1, 1, -32768, -32768));
		send_pair(box_pair(8388607, 8388607, 8388607, 8388607, 8388600, 8388600,
			8388607, 8388607, 2, 1, 32767, 32767));
		send_pair(box_pair(-8388608, 8388607, 8388607, 8388607, 0, 0,
			8388607, 8388607, 9, 2, 1, -1));
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_ELAST, 0);   write_reg(REG_CUTOFF, 0); end
				1: begin write_reg(REG_ELAST, 256); write_reg(REG_CUTOFF, 32767); end
				2: begin write_reg(REG_ELAST, 511); write_reg(REG_CUTOFF, 0); end
				3: begin write_reg(REG_ELAST, 200); write_reg(REG_CUTOFF, 40); end
				4: begin write_reg(REG_ELAST, 256); write_reg(REG_CUTOFF, 1); end
				default: begin write_reg(REG_ELAST, $urandom_range(511));
					write_reg(REG_CUTOFF, $urandom_range(300)); end
			endcase
			case (phase / 2)
				0: begin tx_idle = 36; rx_idle = 45; end
				1: begin tx_idle = 45; rx_idle = 36; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			repeat (138) send_pair(random_pair());
			drain();
		end

		$display("covered %0d box pairs, %0d results checked, six register settings",
			sent, board.checked);
		$display("idling: sender-heavy, receiver-heavy and none; %0d mismatches",
			board.mismatches);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("aabb_collision_resolver regression: pass");
		else
			$display("aabb_collision_resolver regression: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout waiting for results");
		$display("aabb_collision_resolver regression: fail");
		$finish;
	end

endmodule
